[design/cdq_pkg.sv]
package cdq_pkg;

	// default ring depth, one slot always stays free
	localparam int unsigned SlotsDefault = 8;

	// operation codes carried by each item
	typedef enum logic [2:0] {
		OP_PUSH_REAR  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_REAR  = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// memory command from the pointer control to the ring
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

endpackage

[design/cdq_ring.sv]
module cdq_ring #(
	parameter int unsigned SLOTS = cdq_pkg::SlotsDefault
) (
	input  logic                    clk,
	input  cdq_pkg::mem_cmd_t       cmd,
	input  logic [$clog2(SLOTS)-1:0] addr,
	input  logic [31:0]             wdata,
	output logic [31:0]             rdata_s1
);
	import cdq_pkg::*;

	logic [31:0] ring_mem [SLOTS];

	// single port ring, read data registered
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			ring_mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_s1 <= ring_mem[addr];
		end
	end

endmodule

[design/cdq_ctrl.sv]
module cdq_ctrl #(
	parameter int unsigned SLOTS = cdq_pkg::SlotsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               opcode,
	output logic                     out_valid,
	input  logic                     out_ready,
	output cdq_pkg::mem_cmd_t        cmd,
	output logic [$clog2(SLOTS)-1:0] addr,
	output logic                     rd_ok_s1,
	output cdq_pkg::status_t         status_s1,
	output logic                     full_s1,
	output logic                     empty_s1
);
	import cdq_pkg::*;

	localparam int unsigned AW = $clog2(SLOTS);
	localparam logic [AW-1:0] LastSlot = AW'(SLOTS - 1);

	logic [AW-1:0] front_q, rear_q;
	logic [AW-1:0] front_nx, rear_nx;
	logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec;
	logic          valid_s1;
	logic          accept;
	logic          ring_empty, is_full;
	logic          rd_req, wr_req;
	status_t       st_nx;

	// ring pointer neighbors with wrap at any depth
	assign front_inc = (front_q == LastSlot) ? '0 : front_q + AW'(1);
	assign front_dec = (front_q == '0) ? LastSlot : front_q - AW'(1);
	assign rear_inc  = (rear_q == LastSlot) ? '0 : rear_q + AW'(1);
	assign rear_dec  = (rear_q == '0) ? LastSlot : rear_q - AW'(1);

	assign ring_empty = (front_q == rear_q);
	assign is_full    = (rear_inc == front_q);

	// output stage frees when empty or taken
	assign in_ready  = !valid_s1 || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_s1;

	// operation decode
	always_comb begin
		front_nx = front_q;
		rear_nx  = rear_q;
		addr     = rear_q;
		rd_req   = 1'b0;
		wr_req   = 1'b0;
		st_nx    = ST_DONE;
		unique case (op_t'(opcode))
			OP_PUSH_REAR: begin
				addr = rear_inc;
				if (is_full) begin
					st_nx = ST_FULL;
				end else begin
					wr_req  = 1'b1;
					rear_nx = rear_inc;
				end
			end
			OP_PUSH_FRONT: begin
				addr = front_q;
				if (is_full) begin
					st_nx = ST_FULL;
				end else begin
					wr_req   = 1'b1;
					front_nx = front_dec;
				end
			end
			OP_POP_FRONT: begin
				addr = front_inc;
				if (ring_empty) begin
					st_nx = ST_EMPTY;
				end else begin
					rd_req   = 1'b1;
					front_nx = front_inc;
				end
			end
			OP_POP_REAR: begin
				addr = rear_q;
				if (ring_empty) begin
					st_nx = ST_EMPTY;
				end else begin
					rd_req  = 1'b1;
					rear_nx = rear_dec;
				end
			end
			OP_PEEK_FRONT: begin
				addr = front_inc;
				if (ring_empty) begin
					st_nx = ST_EMPTY;
				end else begin
					rd_req = 1'b1;
				end
			end
			OP_PEEK_REAR: begin
				addr = rear_q;
				if (ring_empty) begin
					st_nx = ST_EMPTY;
				end else begin
					rd_req = 1'b1;
				end
			end
			default: begin
				st_nx = ST_DONE;
			end
		endcase
	end

	assign cmd.wr = accept && wr_req;
	assign cmd.rd = accept && rd_req;

	// pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			rear_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				front_q <= front_nx;
				rear_q  <= rear_nx;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// result status for the item in the output stage
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_nx;
			rd_ok_s1  <= rd_req;
			empty_s1  <= (front_nx == rear_nx);
			full_s1   <= (((rear_nx == LastSlot) ? '0 : rear_nx + AW'(1)) == front_nx);
		end
	end

endmodule

[design/circular_deque_top.sv]
// the result is registered and valid in the cycle after an item is accepted
// throughput: one item per cycle while the output is not stalled; each item makes at
// most one access to the ring memory port and moves at most one pointer register
// a stalled output holds its item and the next item is taken as it leaves
// reset: front and rear pointers cleared, deque empty; ring words not cleared
module circular_deque_top #(
	parameter int unsigned SLOTS = cdq_pkg::SlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic signed [31:0] value_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] value_out,
	output logic [1:0]  status,
	output logic        now_full,
	output logic        now_empty
);
	import cdq_pkg::*;

	localparam int unsigned AW = $clog2(SLOTS);

	mem_cmd_t      cmd;
	logic [AW-1:0] addr;
	logic [31:0]   rdata_s1;
	logic          rd_ok_s1;
	status_t       status_s1;

	// pointer control and output stage
	cdq_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.addr      (addr),
		.rd_ok_s1  (rd_ok_s1),
		.status_s1 (status_s1),
		.full_s1   (now_full),
		.empty_s1  (now_empty)
	);

	// ring storage
	cdq_ring #(
		.SLOTS(SLOTS)
	) u_ring (
		.clk      (clk),
		.cmd      (cmd),
		.addr     (addr),
		.wdata    (value_in),
		.rdata_s1 (rdata_s1)
	);

	// zero the word unless this item read the ring
	assign value_out = rd_ok_s1 ? $signed(rdata_s1) : 32'sd0;
	assign status    = status_s1;

	// a refused push leaves the deque full
	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_s1 == ST_FULL) |-> now_full)
		else $error("refused push without full deque");

	// a refused read leaves the deque empty
	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_s1 == ST_EMPTY) |-> now_empty)
		else $error("refused read without empty deque");

	// never full and empty at once
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(now_full && now_empty))
		else $error("full and empty both set");

	// the ring is read or written only for an accepted item
	a_mem_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr || cmd.rd) |-> (in_valid && in_ready && !(cmd.wr && cmd.rd)))
		else $error("ring access without accepted item");

endmodule
